// ===== sv/dcrc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcrc_pkg
// Shared types, register indexes and bitwise CRC byte updates for the dual
// CRC-16 / CRC-32 engine.
// ----------------------------------------------------------------------------
package dcrc_pkg;

   localparam int BYTES_PER_ITEM = 8;
   localparam int DATA_BYTES     = 8;
   localparam int BYTE_LIMIT     = (BYTES_PER_ITEM < DATA_BYTES) ? BYTES_PER_ITEM : DATA_BYTES;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 32;

   localparam logic [CSR_INDEX_W-1:0] CSR_CRC16_ENABLE = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_CRC32_ENABLE = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_CRC16_POLY   = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_CRC32_POLY   = 2'd3;

   localparam logic [15:0] CRC16_POLY_RESET = 16'hA001;
   localparam logic [31:0] CRC32_POLY_RESET = 32'hEDB8_8320;

   typedef struct packed {
      logic [63:0] data_bytes;
      logic [3:0]  byte_count;
      logic        first;
   } req_type;

   typedef struct packed {
      logic [15:0] crc16_value;
      logic [31:0] crc32_value;
   } rsp_type;

   typedef struct packed {
      logic        crc16_enable;
      logic        crc32_enable;
      logic [15:0] crc16_poly;
      logic [31:0] crc32_poly;
   } cfg_type;

   // One reflected byte update, LSB first.
   function automatic logic [15:0] crc16_byte(input logic [15:0] c_in,
                                              input logic [7:0]  b,
                                              input logic [15:0] poly);
      logic [15:0] c;
      c = c_in ^ {8'h00, b};
      for (int k = 0; k < 8; k++) begin
         c = c[0] ? ((c >> 1) ^ poly) : (c >> 1);
      end
      return c;
   endfunction

   function automatic logic [31:0] crc32_byte(input logic [31:0] c_in,
                                              input logic [7:0]  b,
                                              input logic [31:0] poly);
      logic [31:0] c;
      c = c_in ^ {24'h000000, b};
      for (int k = 0; k < 8; k++) begin
         c = c[0] ? ((c >> 1) ^ poly) : (c >> 1);
      end
      return c;
   endfunction

endpackage

// ===== sv/dual_crc16_crc32_engine.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dual_crc16_crc32_engine
// Reflected CRC-16 and finished-form CRC-32 over up to eight bytes per word.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel (req_valid / req_stall / req_data) carries one word of up
//   to eight message bytes, byte 0 in bits 7:0 first, a byte count and a
//   first flag that restarts both CRCs. Each word gives exactly one response
//   word (rsp_valid / rsp_stall / rsp_data) with both running CRC values.
//   rsp_valid rises once the word has passed from the input register through
//   the eight-byte update of both CRCs, which writes the response register
//   and the running CRCs together. Throughput is one word per cycle while the
//   receiver does not stall, set by the feedback of the running CRCs through
//   the unrolled byte update.
//   When the receiver stalls, the response register holds; the input register
//   still takes one more word, then req_stall rises until the response drains.
//   Reset empties both registers, clears the running CRCs to zero, enables
//   both CRCs and loads the default polynomials (0xA001, 0xEDB88320).
//   Write the csr_ registers only while no word is in flight.
// ----------------------------------------------------------------------------
module dual_crc16_crc32_engine (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  dcrc_pkg::req_type                req_data,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output dcrc_pkg::rsp_type                rsp_data,
   input  logic                             csr_write_enable,
   input  logic [dcrc_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [dcrc_pkg::CSR_DATA_W-1:0]  csr_data
);

   dcrc_pkg::cfg_type cfg;
   dcrc_pkg::rsp_type result;

   dcrc_pkg::req_type in_ff;
   logic              in_valid_ff;
   logic              in_valid_in;
   dcrc_pkg::rsp_type rsp_ff;
   logic              rsp_valid_ff;
   logic              rsp_valid_in;

   logic advance;
   logic req_take;

   dcrc_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .cfg              (cfg)
   );

   dcrc_core u_core (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .item    (in_ff),
      .cfg     (cfg),
      .result  (result)
   );

   // move the held word into the response register when it is empty or its word is being taken
   assign advance   = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      in_valid_in  = req_take || (in_valid_ff && !advance);
      rsp_valid_in = advance || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_ff <= req_data;
      end
      if (advance) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> in_valid_ff && rsp_valid_ff)
      else $error("request stalled with a free pipeline");

   a_advance_fills_rsp: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid_ff)
      else $error("advanced word did not reach the response register");

   a_held_word_stable: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff && $stable(in_ff))
      else $error("held input word lost or changed");

   a_rsp_drains: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_stall && !advance |=> !rsp_valid_ff)
      else $error("taken response word repeated");

endmodule

// ===== sv/dcrc_csr.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcrc_csr
// Configuration registers: CRC enables and reflected polynomials.
// ----------------------------------------------------------------------------
module dcrc_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_write_enable,
   input  logic [dcrc_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [dcrc_pkg::CSR_DATA_W-1:0]     csr_data,
   output dcrc_pkg::cfg_type                   cfg
);

   dcrc_pkg::cfg_type cfg_ff;
   dcrc_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            dcrc_pkg::CSR_CRC16_ENABLE: cfg_in.crc16_enable = csr_data[0];
            dcrc_pkg::CSR_CRC32_ENABLE: cfg_in.crc32_enable = csr_data[0];
            dcrc_pkg::CSR_CRC16_POLY:   cfg_in.crc16_poly   = csr_data[15:0];
            dcrc_pkg::CSR_CRC32_POLY:   cfg_in.crc32_poly   = csr_data[31:0];
            default:                    cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.crc16_enable <= 1'b1;
         cfg_ff.crc32_enable <= 1'b1;
         cfg_ff.crc16_poly   <= dcrc_pkg::CRC16_POLY_RESET;
         cfg_ff.crc32_poly   <= dcrc_pkg::CRC32_POLY_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== sv/dcrc_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcrc_core
// Running CRC registers and the unrolled eight-byte update of both CRCs.
// ----------------------------------------------------------------------------
module dcrc_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              advance,
   input  dcrc_pkg::req_type item,
   input  dcrc_pkg::cfg_type cfg,
   output dcrc_pkg::rsp_type result
);

   localparam logic [3:0] LIMIT = 4'(dcrc_pkg::BYTE_LIMIT);

   logic [15:0] crc16_ff;
   logic [15:0] crc16_in;
   logic [31:0] crc32_ff;
   logic [31:0] crc32_in;

   logic [3:0]  count_sat;
   logic [15:0] base16;
   logic [31:0] base32;
   logic [15:0] c16;
   logic [31:0] c32;

   always_comb begin
      count_sat = (item.byte_count > LIMIT) ? LIMIT : item.byte_count;
      // first clears both, whatever the enables
      base16 = item.first ? 16'h0000 : crc16_ff;
      base32 = item.first ? 32'h0000_0000 : crc32_ff;
      c16 = base16;
      c32 = ~base32;
      for (int i = 0; i < dcrc_pkg::BYTE_LIMIT; i++) begin
         if (4'(i) < count_sat) begin
            c16 = dcrc_pkg::crc16_byte(c16, item.data_bytes[8*i +: 8], cfg.crc16_poly);
            c32 = dcrc_pkg::crc32_byte(c32, item.data_bytes[8*i +: 8], cfg.crc32_poly);
         end
      end
      crc16_in = cfg.crc16_enable ? c16 : base16;
      crc32_in = cfg.crc32_enable ? ~c32 : base32;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc16_ff <= 16'h0000;
         crc32_ff <= 32'h0000_0000;
      end else if (advance) begin
         crc16_ff <= crc16_in;
         crc32_ff <= crc32_in;
      end
   end

   assign result.crc16_value = crc16_in;
   assign result.crc32_value = crc32_in;

endmodule
